### design/lfu_pkg.sv
// Shared types and constants for the LFU cache policy block.
// Used by lfu_ctrl, lfu_dp and lfu_cache_policy_top; no dependencies.
`default_nettype none

package lfu_pkg;

    // Command codes carried in the request word
    localparam logic CMD_ACCESS = 1'b0;  // access, insert on miss
    localparam logic CMD_LOOKUP = 1'b1;  // lookup only, never inserts

    // Capacity register
    localparam int unsigned CAPACITY_W = 5;
    localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 5'd16;

    // Port payload widths
    localparam int unsigned KEY_W = 32;
    localparam int unsigned MIN_W = 16;

    // Request word
    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
    } req_t;

    // Result word
    typedef struct packed {
        logic             hit;
        logic [MIN_W-1:0] min_count;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture request, clear scan accumulators
        logic scan;    // read one entry and advance the scan address
        logic commit;  // apply the update and register the result
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;  // scan address is on the last entry
    } dp_status_t;

endpackage

`default_nettype wire

### design/lfu_ctrl.sv
// Sequencer for the LFU cache policy block: load, scan, drain, commit.
// Depends on lfu_pkg for the command and status structs.
`default_nettype none

module lfu_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire lfu_pkg::dp_status_t status,
    output      lfu_pkg::ctrl_cmd_t  ctrl_cmd,
    output      logic                busy,
    output      logic                done
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        ctrl_cmd.load   = (state_reg == ST_IDLE) && start;
        ctrl_cmd.scan   = (state_reg == ST_SCAN);
        ctrl_cmd.commit = (state_reg == ST_COMMIT);
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    // State and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_COMMIT);
        end
    end

endmodule

`default_nettype wire

### design/lfu_dp.sv
// Datapath of the LFU cache policy block: entry stores, scan unit,
// capacity register, update logic and result register. Depends on lfu_pkg.
`default_nettype none

module lfu_dp
#(
    parameter int unsigned ENTRIES    = 16,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned COUNT_BITS = 16
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lfu_pkg::ctrl_cmd_t                  ctrl_cmd,
    input  wire lfu_pkg::req_t                       request,
    input  wire logic                                cfg_we,
    input  wire logic [lfu_pkg::CAPACITY_W-1:0]      cfg_data,
    output      lfu_pkg::dp_status_t                 status,
    output      lfu_pkg::rsp_t                       response
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);
    localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
    localparam int unsigned CMP_W =
        (OCC_W > lfu_pkg::CAPACITY_W) ? OCC_W : lfu_pkg::CAPACITY_W;
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [CMP_W-1:0]      ENTRIES_C = CMP_W'(ENTRIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // Entry stores (memories) and valid bits
    logic [KEY_BITS-1:0]   mem_key [ENTRIES];
    logic [COUNT_BITS-1:0] mem_cnt [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg;

    // Block state
    logic [lfu_pkg::CAPACITY_W-1:0] capacity_reg;
    logic [OCC_W-1:0]               occ_reg;
    logic [COUNT_BITS-1:0]          min_reg;

    // Captured request
    logic                command_reg;
    logic [KEY_BITS-1:0] key_reg;

    // Scan address and read stage
    logic [IDX_W-1:0]      addr_reg;
    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [COUNT_BITS-1:0] rd_cnt_reg;

    // Scan accumulators
    logic                  hit_any_reg,  hit_any_next;
    logic [IDX_W-1:0]      hit_idx_reg,  hit_idx_next;
    logic [COUNT_BITS-1:0] hit_cnt_reg,  hit_cnt_next;
    logic                  min_any_reg,  min_any_next;
    logic [COUNT_BITS-1:0] min_acc_reg,  min_acc_next;
    logic                  vic_any_reg,  vic_any_next;
    logic [IDX_W-1:0]      vic_idx_reg,  vic_idx_next;
    logic [COUNT_BITS-1:0] vic_cnt_reg,  vic_cnt_next;
    logic [KEY_BITS-1:0]   vic_key_reg,  vic_key_next;
    logic                  free_any_reg, free_any_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;

    // Scan evaluation terms
    logic                  ev_valid;
    logic                  ev_match;
    logic [COUNT_BITS-1:0] ev_inc;
    logic [COUNT_BITS-1:0] ev_cnt;

    // Commit terms
    logic [CMP_W-1:0]      cap_eff;
    logic                  occ_lt;
    logic                  use_free;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_cnt;
    logic [OCC_W-1:0]      occ_next;
    logic [COUNT_BITS-1:0] min_next;
    logic [COUNT_BITS-1:0] min_out;

    assign status.scan_last = (addr_reg == LAST_IDX);

    // Evaluate the entry that came out of the read stage
    always_comb
    begin
        ev_valid = rd_vld_reg && valid_reg[rd_idx_reg];
        ev_match = ev_valid && (rd_key_reg == key_reg);
        ev_inc   = (rd_cnt_reg == COUNT_MAX) ? rd_cnt_reg : rd_cnt_reg + COUNT_ONE;
        ev_cnt   = ev_match ? ev_inc : rd_cnt_reg;
    end

    // Accumulators: hit slot, minimum after the hit, victim, first free slot
    always_comb
    begin
        hit_any_next  = hit_any_reg;
        hit_idx_next  = hit_idx_reg;
        hit_cnt_next  = hit_cnt_reg;
        min_any_next  = min_any_reg;
        min_acc_next  = min_acc_reg;
        vic_any_next  = vic_any_reg;
        vic_idx_next  = vic_idx_reg;
        vic_cnt_next  = vic_cnt_reg;
        vic_key_next  = vic_key_reg;
        free_any_next = free_any_reg;
        free_idx_next = free_idx_reg;
        if (ctrl_cmd.load)
        begin
            hit_any_next  = 1'b0;
            min_any_next  = 1'b0;
            vic_any_next  = 1'b0;
            free_any_next = 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (ev_match)
            begin
                hit_any_next = 1'b1;
                hit_idx_next = rd_idx_reg;
                hit_cnt_next = ev_inc;
            end
            if (ev_valid && (!min_any_reg || (ev_cnt < min_acc_reg)))
            begin
                min_any_next = 1'b1;
                min_acc_next = ev_cnt;
            end
            if (ev_valid && (!vic_any_reg || (rd_cnt_reg < vic_cnt_reg) ||
                ((rd_cnt_reg == vic_cnt_reg) && (rd_key_reg < vic_key_reg))))
            begin
                vic_any_next = 1'b1;
                vic_idx_next = rd_idx_reg;
                vic_cnt_next = rd_cnt_reg;
                vic_key_next = rd_key_reg;
            end
            if (!ev_valid && !free_any_reg)
            begin
                free_any_next = 1'b1;
                free_idx_next = rd_idx_reg;
            end
        end
    end

    // Update decision
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(capacity_reg) > ENTRIES_C)
        begin
            cap_eff = ENTRIES_C;
        end
        else
        begin
            cap_eff = CMP_W'(capacity_reg);
        end
        occ_lt   = (CMP_W'(occ_reg) < cap_eff);
        use_free = occ_lt ? free_any_reg : !vic_any_reg;
        wr_en    = 1'b0;
        wr_addr  = hit_idx_reg;
        wr_cnt   = hit_cnt_reg;
        occ_next = occ_reg;
        min_next = min_reg;
        if (hit_any_reg)
        begin
            wr_en    = ctrl_cmd.commit;
            min_next = min_acc_reg;
        end
        else if (command_reg == lfu_pkg::CMD_ACCESS && (free_any_reg || vic_any_reg))
        begin
            wr_en    = ctrl_cmd.commit;
            wr_addr  = use_free ? free_idx_reg : vic_idx_reg;
            wr_cnt   = COUNT_ONE;
            min_next = COUNT_ONE;
            if (use_free)
            begin
                occ_next = occ_reg + OCC_W'(1);
            end
        end
        min_out = (occ_next == '0) ? '0 : min_next;
    end

    // Entry stores: one write at commit, one registered read per scan step
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_key[wr_addr] <= key_reg;
            mem_cnt[wr_addr] <= wr_cnt;
        end
        if (ctrl_cmd.scan)
        begin
            rd_key_reg <= mem_key[addr_reg];
            rd_cnt_reg <= mem_cnt[addr_reg];
            rd_idx_reg <= addr_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load)
        begin
            command_reg <= request.command;
            key_reg     <= KEY_BITS'(request.key);
        end
        if (ctrl_cmd.commit)
        begin
            response.hit       <= hit_any_reg;
            response.min_count <= lfu_pkg::MIN_W'(min_out);
        end
        hit_idx_reg  <= hit_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        min_acc_reg  <= min_acc_next;
        vic_idx_reg  <= vic_idx_next;
        vic_cnt_reg  <= vic_cnt_next;
        vic_key_reg  <= vic_key_next;
        free_idx_reg <= free_idx_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            capacity_reg <= lfu_pkg::CAPACITY_RESET;
            occ_reg      <= '0;
            min_reg      <= '0;
            addr_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            hit_any_reg  <= 1'b0;
            min_any_reg  <= 1'b0;
            vic_any_reg  <= 1'b0;
            free_any_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            if (ctrl_cmd.load)
            begin
                addr_reg <= '0;
            end
            else if (ctrl_cmd.scan)
            begin
                addr_reg <= addr_reg + IDX_W'(1);
            end
            rd_vld_reg <= ctrl_cmd.scan;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctrl_cmd.commit)
            begin
                occ_reg <= occ_next;
                min_reg <= min_next;
            end
            hit_any_reg  <= hit_any_next;
            min_any_reg  <= min_any_next;
            vic_any_reg  <= vic_any_next;
            free_any_reg <= free_any_next;
        end
    end

endmodule

`default_nettype wire

### design/lfu_cache_policy_top.sv
// LFU cache policy block, top level: controller plus datapath.
// Depends on lfu_pkg, lfu_ctrl and lfu_dp.
//
// Usage:
//   Request word (command, key) is taken at a rising edge with start high
//   and busy low. Command access counts a hit or inserts the key with use
//   count 1, evicting the least used entry (ties: smallest key) when the
//   occupancy has reached the capacity; command lookup only counts a hit.
//   Exactly one result word (hit, min_count) per request is shown on
//   response for one cycle with done high. The receiver cannot stall it.
//   Capacity is written through cfg_we/cfg_data while the block is idle.
// Timing:
//   The datapath scans the entry store one entry per cycle through a
//   single registered read port. After the last scan step the sequencer
//   passes through its drain and commit states; the result and done are
//   registered from commit, and busy falls in the cycle done is high, so
//   a new request can then be issued.
// Reset:
//   rst_n clears all valid bits, the occupancy and minimum count, and sets
//   capacity to 16. The block is ready right after reset.
`default_nettype none

module lfu_cache_policy_top
#(
    parameter int unsigned ENTRIES    = 16,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned COUNT_BITS = 16
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output      logic                           busy,
    input  wire lfu_pkg::req_t                  request,
    output      logic                           done,
    output      lfu_pkg::rsp_t                  response,
    input  wire logic                           cfg_we,
    input  wire logic [lfu_pkg::CAPACITY_W-1:0] cfg_data
);

    lfu_pkg::ctrl_cmd_t  ctrl_cmd;
    lfu_pkg::dp_status_t status;

    // Sequencer
    lfu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .status   (status),
        .ctrl_cmd (ctrl_cmd),
        .busy     (busy),
        .done     (done)
    );

    // Stores, scan unit and update logic
    lfu_dp
    #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_cmd (ctrl_cmd),
        .request  (request),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .status   (status),
        .response (response)
    );

    // Checks
    a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.commit |=> done)
        else $error("result strobe missing after commit");

    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.scan |-> busy)
        else $error("scan step while not busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not start a scan");

endmodule

`default_nettype wire
